### hdl/v6p_pkg.sv
package v6p_pkg;

    // Longest text that positions count to; positions saturate one below it
    localparam int MAX_TEXT_LEN = 64;
    localparam int POS_W = $clog2(MAX_TEXT_LEN);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_LEN - 1);

    // Character classes
    localparam logic [2:0] CLS_DEC   = 3'd0;
    localparam logic [2:0] CLS_ALPHA = 3'd1;
    localparam logic [2:0] CLS_COLON = 3'd2;
    localparam logic [2:0] CLS_DOT   = 3'd3;
    localparam logic [2:0] CLS_LBR   = 3'd4;
    localparam logic [2:0] CLS_RBR   = 3'd5;
    localparam logic [2:0] CLS_OTHER = 3'd6;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW   = 3'd3;
    localparam logic [2:0] ST_NO_BRACKET = 3'd4;

    // Register map (word index)
    localparam logic REG_BRACKET_MODE = 1'b0;

    // Queue between classifier and parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } text_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] error_position;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [5:0] consumed_length;
    } result_t;

    // Classified character as it travels to the parser
    typedef struct packed {
        logic [2:0]       cls;
        logic [3:0]       val;
        logic [POS_W-1:0] pos;
        logic             last;
    } char_item_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        sat_inc = (p == POS_MAX) ? p : p + POS_W'(1);
    endfunction

endpackage

### hdl/ipv6_text_address_parser.sv
// IPv6 address text parser. Characters are pushed one per transfer with is_last
// on the final one; exactly one result per text appears in the result register
// after the last character. A classifier tags each character and counts its
// position; a four-entry queue decouples it from the parser, which handles one
// character per cycle unless replaying, ending a text or awaiting a result pop.
// A '.' ending a hex group replays the kept digits as decimal, then the dot; the
// text end takes an end check, then rearrangement and result load together.
// bracket_mode sits at address 0; write it only while no text is in flight.
module ipv6_text_address_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  v6p_pkg::text_item_t item,
    output logic                empty,
    input  logic                pop,
    output v6p_pkg::result_t    result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                bracket_mode_reg;
    logic                bracket_mode_next;
    logic                take;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    v6p_pkg::char_item_t entry;
    v6p_pkg::char_item_t q_data;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == v6p_pkg::REG_BRACKET_MODE) ? {31'd0, bracket_mode_reg}
                                                            : 32'd0;

    always_comb
    begin
        bracket_mode_next = bracket_mode_reg;
        if (psel && penable && pwrite && pready && paddr[2] == v6p_pkg::REG_BRACKET_MODE)
            bracket_mode_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bracket_mode_reg <= 1'b0;
        else
            bracket_mode_reg <= bracket_mode_next;
    end

    assign full = q_full;
    assign take = push && !q_full;

    v6p_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .entry (entry)
    );

    v6p_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (take),
        .wdata (entry),
        .rd    (q_pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    v6p_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bracket_mode (bracket_mode_reg),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .result       (result),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

### hdl/v6p_front.sv
module v6p_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  v6p_pkg::text_item_t  item,
    output v6p_pkg::char_item_t  entry
);

    logic [v6p_pkg::POS_W-1:0] pos_reg;
    logic [v6p_pkg::POS_W-1:0] pos_next;
    logic [7:0]                c;

    assign c = item.text_char;

    // Classify the character and find its digit value
    always_comb
    begin
        entry.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            entry.cls = v6p_pkg::CLS_DEC;
            entry.val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            entry.cls = v6p_pkg::CLS_ALPHA;
            entry.val = c[3:0] + 4'd9;
        end
        else if (c == 8'h3A)
            entry.cls = v6p_pkg::CLS_COLON;
        else if (c == 8'h2E)
            entry.cls = v6p_pkg::CLS_DOT;
        else if (c == 8'h5B)
            entry.cls = v6p_pkg::CLS_LBR;
        else if (c == 8'h5D)
            entry.cls = v6p_pkg::CLS_RBR;
        else
            entry.cls = v6p_pkg::CLS_OTHER;
        entry.pos  = pos_reg;
        entry.last = item.is_last;
    end

    // Advance the character position, restart after the last character
    always_comb
    begin
        pos_next = pos_reg;
        if (take)
            pos_next = item.is_last ? '0 : v6p_pkg::sat_inc(pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

### hdl/v6p_queue.sv
module v6p_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  v6p_pkg::char_item_t wdata,
    input  logic                rd,
    output v6p_pkg::char_item_t rdata,
    output logic                full,
    output logic                empty
);

    v6p_pkg::char_item_t            mem_reg [v6p_pkg::QUEUE_DEPTH];
    logic [v6p_pkg::QPTR_W-1:0]     wptr_reg;
    logic [v6p_pkg::QPTR_W-1:0]     rptr_reg;
    logic [v6p_pkg::QPTR_W:0]       count_reg;
    logic                           do_wr;
    logic                           do_rd;

    assign full  = (count_reg == (v6p_pkg::QPTR_W + 1)'(v6p_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rptr_reg];

    // Store a transfer at the tail
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wdata;
    end

    // Move pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + v6p_pkg::QPTR_W'(1);
            if (do_rd)
                rptr_reg <= rptr_reg + v6p_pkg::QPTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (v6p_pkg::QPTR_W + 1)'(1);
            else if (!do_wr && do_rd)
                count_reg <= count_reg - (v6p_pkg::QPTR_W + 1)'(1);
        end
    end

endmodule

### hdl/v6p_back.sv
module v6p_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                bracket_mode,
    input  logic                q_empty,
    input  v6p_pkg::char_item_t q_data,
    output logic                q_pop,
    output v6p_pkg::result_t    result,
    output logic                empty,
    input  logic                pop
);

    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_FIRST    = 4'd1;
    localparam logic [3:0] PH_COLON2   = 4'd2;
    localparam logic [3:0] PH_PIECE    = 4'd3;
    localparam logic [3:0] PH_PIECE_NE = 4'd4;
    localparam logic [3:0] PH_GROUP    = 4'd5;
    localparam logic [3:0] PH_V4_NUM   = 4'd6;
    localparam logic [3:0] PH_V4_DIG   = 4'd7;
    localparam logic [3:0] PH_DONE     = 4'd8;

    localparam logic [1:0] S_CHAR   = 2'd0;
    localparam logic [1:0] S_REPLAY = 2'd1;
    localparam logic [1:0] S_EOF    = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam int PW = v6p_pkg::POS_W;

    logic [1:0]    seq_reg, seq_next;
    logic [3:0]    phase_reg, phase_next;
    logic [3:0]    pp_reg, pp_next;
    logic [3:0]    cp_reg, cp_next;
    logic          cseen_reg, cseen_next;
    logic [3:0]    gch_reg [4];
    logic [3:0]    gch_next [4];
    logic [2:0]    gcnt_reg, gcnt_next;
    logic [7:0]    oct_reg, oct_next;
    logic [2:0]    octs_reg, octs_next;
    logic [15:0]   store_reg [8];
    logic [15:0]   store_next [8];
    logic [2:0]    st_reg, st_next;
    logic [PW-1:0] epos_reg, epos_next;
    logic [PW-1:0] len_reg, len_next;
    logic [2:0]    ridx_reg, ridx_next;
    logic [PW-1:0] rfirst_reg, rfirst_next;
    logic [PW-1:0] rdot_reg, rdot_next;
    logic          rlast_reg, rlast_next;
    logic [PW-1:0] eofpos_reg, eofpos_next;
    logic          out_valid_reg, out_valid_next;
    v6p_pkg::result_t res_reg, res_next;

    logic          active;
    logic          in_eof, eof, in_te;
    logic [2:0]    cls;
    logic [3:0]    val;
    logic [PW-1:0] pos;
    logic          is_hex;
    logic          rep_start;
    logic          f_req, fin_req, fin_te, pt_req;
    logic [2:0]    f_st;
    logic [PW-1:0] f_pos, first;
    logic [15:0]   gval;
    logic [11:0]   v;
    logic [2:0]    octs_inc;
    logic [127:0]  flat, keep, head, tail;
    logic [7:0]    lo_sh, hi_sh;

    // Select what is fed this cycle
    always_comb
    begin
        in_eof = 1'b0;
        in_te  = 1'b0;
        cls    = q_data.cls;
        val    = q_data.val;
        pos    = q_data.pos;
        active = 1'b0;
        case (seq_reg)
            S_CHAR:
                active = !q_empty && (phase_reg != PH_DONE);
            S_REPLAY:
            begin
                active = (phase_reg != PH_DONE);
                if (ridx_reg < gcnt_reg)
                begin
                    val = gch_reg[ridx_reg[1:0]];
                    cls = (val < 4'd10) ? v6p_pkg::CLS_DEC : v6p_pkg::CLS_ALPHA;
                    pos = PW'(rfirst_reg + PW'(ridx_reg));
                end
                else
                begin
                    cls = v6p_pkg::CLS_DOT;
                    pos = rdot_reg;
                end
            end
            S_EOF:
            begin
                in_eof = 1'b1;
                in_te  = 1'b1;
                cls    = v6p_pkg::CLS_OTHER;
                pos    = eofpos_reg;
                active = (phase_reg != PH_DONE);
            end
            default:
                active = 1'b0;
        endcase
    end

    assign eof = in_eof || (bracket_mode && cls == v6p_pkg::CLS_RBR && phase_reg != PH_START);
    assign is_hex = (cls == v6p_pkg::CLS_DEC) || (cls == v6p_pkg::CLS_ALPHA);
    assign first = (pos >= PW'(gcnt_reg)) ? pos - PW'(gcnt_reg) : '0;
    assign v = 12'(oct_reg) * 12'd10 + 12'(val);
    assign octs_inc = octs_reg + 3'd1;

    // Fold the kept hex digits into one piece
    always_comb
    begin
        gval = 16'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < gcnt_reg)
                gval = {gval[11:0], gch_reg[i]};
        end
    end

    // Rearrange pieces after the compression point to the tail
    always_comb
    begin
        flat  = {store_reg[0], store_reg[1], store_reg[2], store_reg[3],
                 store_reg[4], store_reg[5], store_reg[6], store_reg[7]};
        lo_sh = {cp_reg, 4'd0};
        hi_sh = {4'd8 - pp_reg, 4'd0};
        keep  = ~({128{1'b1}} >> lo_sh);
        head  = flat & keep;
        tail  = (flat & ~keep) >> hi_sh;
    end

    // Parse one character step
    always_comb
    begin
        phase_next = phase_reg;
        pp_next    = pp_reg;
        cp_next    = cp_reg;
        cseen_next = cseen_reg;
        gch_next   = gch_reg;
        gcnt_next  = gcnt_reg;
        oct_next   = oct_reg;
        octs_next  = octs_reg;
        store_next = store_reg;
        st_next    = st_reg;
        epos_next  = epos_reg;
        len_next   = len_reg;
        f_req      = 1'b0;
        f_st       = v6p_pkg::ST_OK;
        f_pos      = pos;
        fin_req    = 1'b0;
        fin_te     = in_te;
        pt_req     = 1'b0;
        rep_start  = 1'b0;

        if (active)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (bracket_mode)
                    begin
                        if (cls == v6p_pkg::CLS_LBR)
                            phase_next = PH_FIRST;
                        else
                        begin
                            f_req = 1'b1;
                            f_st  = v6p_pkg::ST_NO_BRACKET;
                            f_pos = '0;
                        end
                    end
                    else if (cls == v6p_pkg::CLS_COLON)
                        phase_next = PH_COLON2;
                    else
                        pt_req = 1'b1;
                end
                PH_FIRST:
                begin
                    if (eof)
                    begin
                        f_req = 1'b1;
                        f_st  = v6p_pkg::ST_INCOMPLETE;
                    end
                    else if (cls == v6p_pkg::CLS_COLON)
                        phase_next = PH_COLON2;
                    else
                        pt_req = 1'b1;
                end
                PH_COLON2:
                begin
                    if (eof || cls != v6p_pkg::CLS_COLON)
                    begin
                        f_req = 1'b1;
                        f_st  = v6p_pkg::ST_INVALID;
                    end
                    else
                    begin
                        pp_next    = 4'd1;
                        cp_next    = 4'd1;
                        cseen_next = 1'b1;
                        phase_next = PH_PIECE;
                    end
                end
                PH_PIECE:
                begin
                    if (eof)
                        fin_req = 1'b1;
                    else
                        pt_req = 1'b1;
                end
                PH_PIECE_NE:
                begin
                    if (eof)
                    begin
                        f_req = 1'b1;
                        f_st  = v6p_pkg::ST_INVALID;
                    end
                    else
                        pt_req = 1'b1;
                end
                PH_GROUP:
                begin
                    if (!eof && is_hex && gcnt_reg < 3'd4)
                    begin
                        gch_next[gcnt_reg[1:0]] = val;
                        gcnt_next = gcnt_reg + 3'd1;
                    end
                    else if (!eof && cls == v6p_pkg::CLS_DOT)
                    begin
                        if (gcnt_reg == 3'd0)
                        begin
                            f_req = 1'b1;
                            f_st  = v6p_pkg::ST_OVERFLOW;
                        end
                        else if (pp_reg > 4'd6)
                        begin
                            f_req = 1'b1;
                            f_st  = v6p_pkg::ST_OVERFLOW;
                            f_pos = first;
                        end
                        else
                        begin
                            octs_next  = 3'd0;
                            oct_next   = 8'd0;
                            phase_next = PH_V4_NUM;
                            rep_start  = 1'b1;
                        end
                    end
                    else if (!eof && cls != v6p_pkg::CLS_COLON)
                    begin
                        f_req = 1'b1;
                        f_st  = v6p_pkg::ST_INVALID;
                    end
                    else
                    begin
                        store_next[pp_reg[2:0]] = gval;
                        pp_next = pp_reg + 4'd1;
                        if (eof)
                            fin_req = 1'b1;
                        else
                            phase_next = PH_PIECE_NE;
                    end
                end
                PH_V4_NUM:
                begin
                    if (eof || cls != v6p_pkg::CLS_DEC)
                    begin
                        f_req = 1'b1;
                        f_st  = v6p_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        oct_next   = 8'(val);
                        phase_next = PH_V4_DIG;
                    end
                end
                PH_V4_DIG:
                begin
                    if (!eof && cls == v6p_pkg::CLS_DEC)
                    begin
                        if (oct_reg == 8'd0 || v > 12'd255)
                        begin
                            f_req = 1'b1;
                            f_st  = v6p_pkg::ST_INVALID;
                        end
                        else
                            oct_next = v[7:0];
                    end
                    else
                    begin
                        store_next[pp_reg[2:0]] = {store_reg[pp_reg[2:0]][7:0], oct_reg};
                        octs_next = octs_inc;
                        if (octs_inc == 3'd2 || octs_inc == 3'd4)
                            pp_next = pp_reg + 4'd1;
                        if (eof)
                        begin
                            if (octs_inc != 3'd4)
                            begin
                                f_req = 1'b1;
                                f_st  = v6p_pkg::ST_INVALID;
                            end
                            else
                                fin_req = 1'b1;
                        end
                        else if (cls == v6p_pkg::CLS_DOT && octs_inc < 3'd4)
                            phase_next = PH_V4_NUM;
                        else
                        begin
                            f_req = 1'b1;
                            f_st  = v6p_pkg::ST_OVERFLOW;
                        end
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase

            // Start a piece: compression or the first hex digit of a group
            if (pt_req)
            begin
                if (pp_reg == 4'd8)
                begin
                    f_req = 1'b1;
                    f_st  = v6p_pkg::ST_OVERFLOW;
                end
                else if (cls == v6p_pkg::CLS_COLON)
                begin
                    if (cseen_reg)
                    begin
                        f_req = 1'b1;
                        f_st  = v6p_pkg::ST_INVALID;
                    end
                    else
                    begin
                        pp_next    = pp_reg + 4'd1;
                        cp_next    = pp_reg + 4'd1;
                        cseen_next = 1'b1;
                        phase_next = PH_PIECE;
                    end
                end
                else if (is_hex)
                begin
                    gch_next[0] = val;
                    gcnt_next   = 3'd1;
                    phase_next  = PH_GROUP;
                end
                else
                begin
                    f_req = 1'b1;
                    f_st  = (cls == v6p_pkg::CLS_DOT) ? v6p_pkg::ST_OVERFLOW
                                                       : v6p_pkg::ST_INVALID;
                end
            end

            // Close the address
            if (fin_req)
            begin
                if (bracket_mode && fin_te)
                begin
                    f_req = 1'b1;
                    f_st  = v6p_pkg::ST_INCOMPLETE;
                end
                else if (!cseen_next && pp_next != 4'd8)
                begin
                    f_req = 1'b1;
                    f_st  = v6p_pkg::ST_INVALID;
                end
                else
                begin
                    st_next    = v6p_pkg::ST_OK;
                    epos_next  = '0;
                    len_next   = bracket_mode ? v6p_pkg::sat_inc(pos) : pos;
                    phase_next = PH_DONE;
                end
            end

            // Latch an error and stop parsing
            if (f_req)
            begin
                st_next    = f_st;
                epos_next  = f_pos;
                len_next   = '0;
                phase_next = PH_DONE;
            end
        end
    end

    // Sequence characters, replay, end of text and the result transfer
    always_comb
    begin
        seq_next       = seq_reg;
        ridx_next      = ridx_reg;
        rfirst_next    = rfirst_reg;
        rdot_next      = rdot_reg;
        rlast_next     = rlast_reg;
        eofpos_next    = eofpos_reg;
        out_valid_next = out_valid_reg && !pop;
        res_next       = res_reg;
        q_pop          = 1'b0;
        case (seq_reg)
            S_CHAR:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    eofpos_next = v6p_pkg::sat_inc(q_data.pos);
                    if (rep_start)
                    begin
                        seq_next    = S_REPLAY;
                        ridx_next   = 3'd0;
                        rfirst_next = first;
                        rdot_next   = q_data.pos;
                        rlast_next  = q_data.last;
                    end
                    else if (q_data.last)
                        seq_next = S_EOF;
                end
            end
            S_REPLAY:
            begin
                if (ridx_reg == gcnt_reg || phase_next == PH_DONE)
                    seq_next = rlast_reg ? S_EOF : S_CHAR;
                else
                    ridx_next = ridx_reg + 3'd1;
            end
            S_EOF:
                seq_next = S_EMIT;
            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    res_next.status = st_reg;
                    if (st_reg == v6p_pkg::ST_OK)
                    begin
                        res_next.error_position  = 6'd0;
                        res_next.address_high    = head[127:64] | tail[127:64];
                        res_next.address_low     = head[63:0] | tail[63:0];
                        res_next.consumed_length = len_reg[5:0];
                    end
                    else
                    begin
                        res_next.error_position  = epos_reg[5:0];
                        res_next.address_high    = 64'd0;
                        res_next.address_low     = 64'd0;
                        res_next.consumed_length = 6'd0;
                    end
                    seq_next = S_CHAR;
                end
            end
            default:
                seq_next = S_CHAR;
        endcase
    end

    // Hold the result for transfer
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_CHAR;
            phase_reg     <= PH_START;
            pp_reg        <= 4'd0;
            cp_reg        <= 4'd0;
            cseen_reg     <= 1'b0;
            gcnt_reg      <= 3'd0;
            oct_reg       <= 8'd0;
            octs_reg      <= 3'd0;
            st_reg        <= v6p_pkg::ST_OK;
            epos_reg      <= '0;
            len_reg       <= '0;
            ridx_reg      <= 3'd0;
            rfirst_reg    <= '0;
            rdot_reg      <= '0;
            rlast_reg     <= 1'b0;
            eofpos_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                gch_reg[i] <= 4'd0;
            for (int i = 0; i < 8; i++)
                store_reg[i] <= 16'd0;
        end
        else
        begin
            seq_reg       <= seq_next;
            ridx_reg      <= ridx_next;
            rfirst_reg    <= rfirst_next;
            rdot_reg      <= rdot_next;
            rlast_reg     <= rlast_next;
            eofpos_reg    <= eofpos_next;
            out_valid_reg <= out_valid_next;
            if (seq_reg == S_EMIT && seq_next == S_CHAR)
            begin
                // Drop the finished text's state
                phase_reg <= PH_START;
                pp_reg    <= 4'd0;
                cp_reg    <= 4'd0;
                cseen_reg <= 1'b0;
                gcnt_reg  <= 3'd0;
                oct_reg   <= 8'd0;
                octs_reg  <= 3'd0;
                st_reg    <= v6p_pkg::ST_OK;
                epos_reg  <= '0;
                len_reg   <= '0;
                for (int i = 0; i < 4; i++)
                    gch_reg[i] <= 4'd0;
                for (int i = 0; i < 8; i++)
                    store_reg[i] <= 16'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                pp_reg    <= pp_next;
                cp_reg    <= cp_next;
                cseen_reg <= cseen_next;
                gcnt_reg  <= gcnt_next;
                oct_reg   <= oct_next;
                octs_reg  <= octs_next;
                st_reg    <= st_next;
                epos_reg  <= epos_next;
                len_reg   <= len_next;
                gch_reg   <= gch_next;
                store_reg <= store_next;
            end
        end
    end

    assign result = res_reg;
    assign empty  = !out_valid_reg;

`ifndef NO_ASSERTIONS
    a_pp_range: assert property (@(posedge clk) disable iff (!rst_n)
        pp_reg <= 4'd8)
        else $error("piece pointer beyond eight");
    a_cp_order: assert property (@(posedge clk) disable iff (!rst_n)
        cp_reg <= pp_reg)
        else $error("compression point past piece pointer");
    a_replay_phase: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == S_REPLAY |-> (phase_reg == PH_V4_NUM || phase_reg == PH_V4_DIG
                                 || phase_reg == PH_DONE))
        else $error("replay outside dotted tail");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == S_EMIT |-> phase_reg == PH_DONE)
        else $error("result emitted before parse finished");
`endif

endmodule
